>>> rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the chained hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int POOL_CAPACITY = 256;
  localparam int NUM_BUCKETS   = 256;
  localparam int KEY_WIDTH     = 64;
  localparam int VALUE_WIDTH   = 64;
  localparam int HASH_WIDTH    = 32;

  localparam int NODE_W  = $clog2(POOL_CAPACITY);
  localparam int POOL_W  = $clog2(POOL_CAPACITY + 1);
  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int COUNT_W = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REQ_LOOKUP        = 3'd0;
  localparam logic [2:0] REQ_INSERT        = 3'd1;
  localparam logic [2:0] REQ_GET_OR_INSERT = 3'd2;
  localparam logic [2:0] REQ_REMOVE        = 3'd3;
  localparam logic [2:0] REQ_CLEAR         = 3'd4;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_GET_OR_INSERT,
    OP_REMOVE,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_CMP,
    ST_DECIDE,
    ST_ALLOC,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    op_t                    op;
    logic [KEY_WIDTH-1:0]   key;
    logic [HASH_WIDTH-1:0]  hash;
    logic [VALUE_WIDTH-1:0] value;
    logic [BKT_W-1:0]       bucket;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic                   is_new;
    logic [VALUE_WIDTH-1:0] value;
    logic                   status;
    logic [COUNT_W-1:0]     count;
  } res_t;

endpackage

>>> rtl/chained_hash_map_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Steps: IDLE accepts a request, HEAD reads its bucket head, CMP walks the
// chain and DECIDE answers, or ALLOC when a new entry is linked; a clear or
// an unknown request answers as it is accepted; a clear then sweeps the 256
// bucket heads. Requests run one at a time, and an output stall can hold them.
// Reset: synchronous; a sweep empties the buckets before requests run.
// ----------------------------------------------------------------------------
module chained_hash_map_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [63:0] key,
  input  logic [31:0] key_hash,
  input  logic [63:0] value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic        is_new,
  output logic [63:0] value_out,
  output logic        status,
  output logic [8:0]  entry_count
);

  logic          store_values;
  logic          q_full, q_push, q_pop, q_not_empty;
  chm_pkg::req_t q_wdata, q_rdata;
  chm_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      store_values <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      store_values <= cfg_data;
    end
  end

  chm_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .key      (key),
    .key_hash (key_hash),
    .value_in (value_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  chm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  chm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .store_values (store_values),
    .q_not_empty  (q_not_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .res          (res)
  );

  assign found       = res.found;
  assign is_new      = res.is_new;
  assign value_out   = 64'(res.value);
  assign status      = res.status;
  assign entry_count = res.count;

endmodule

>>> rtl/chm_front.sv
// ----------------------------------------------------------------------------
// chm_front
// Accepts request transactions, decodes the operation and picks the bucket.
// ----------------------------------------------------------------------------
module chm_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    req_type,
  input  logic [63:0]   key,
  input  logic [31:0]   key_hash,
  input  logic [63:0]   value_in,
  input  logic          q_full,
  output logic          q_push,
  output chm_pkg::req_t q_wdata
);

  chm_pkg::op_t op;

  always_comb begin
    case (req_type)
      chm_pkg::REQ_LOOKUP:        op = chm_pkg::OP_LOOKUP;
      chm_pkg::REQ_INSERT:        op = chm_pkg::OP_INSERT;
      chm_pkg::REQ_GET_OR_INSERT: op = chm_pkg::OP_GET_OR_INSERT;
      chm_pkg::REQ_REMOVE:        op = chm_pkg::OP_REMOVE;
      chm_pkg::REQ_CLEAR:         op = chm_pkg::OP_CLEAR;
      default:                    op = chm_pkg::OP_NONE;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.op     = op;
    q_wdata.key    = key[chm_pkg::KEY_WIDTH-1:0];
    q_wdata.hash   = key_hash[chm_pkg::HASH_WIDTH-1:0];
    q_wdata.value  = value_in[chm_pkg::VALUE_WIDTH-1:0];
    q_wdata.bucket = key_hash[chm_pkg::BKT_W-1:0];
  end

endmodule

>>> rtl/chm_queue.sv
// ----------------------------------------------------------------------------
// chm_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module chm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  chm_pkg::req_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output chm_pkg::req_t rdata
);

  chm_pkg::req_t mem [chm_pkg::QUEUE_DEPTH];
  logic [chm_pkg::QPTR_W-1:0] wptr;
  logic [chm_pkg::QPTR_W-1:0] rptr;
  logic [chm_pkg::QCNT_W-1:0] count;

  assign full      = count == chm_pkg::QCNT_W'(chm_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign rdata     = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == chm_pkg::QPTR_W'(chm_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == chm_pkg::QPTR_W'(chm_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/chm_back.sv
// ----------------------------------------------------------------------------
// chm_back
// Walks the bucket chain, updates the table and the free stack, and holds
// the result register.
// ----------------------------------------------------------------------------
module chm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          store_values,
  input  logic          q_not_empty,
  input  chm_pkg::req_t q_rdata,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output chm_pkg::res_t res
);

  localparam int NW = chm_pkg::NODE_W;
  localparam int PW = chm_pkg::POOL_W;
  localparam int BW = chm_pkg::BKT_W;
  localparam int HW = chm_pkg::NODE_W + 1;

  chm_pkg::state_t state, state_next;
  chm_pkg::req_t   req;

  // head and link entries carry a valid bit above the node index
  logic [HW-1:0] heads_mem [chm_pkg::NUM_BUCKETS];
  logic [chm_pkg::KEY_WIDTH-1:0]   keys_mem [chm_pkg::POOL_CAPACITY];
  logic [chm_pkg::HASH_WIDTH-1:0]  hash_mem [chm_pkg::POOL_CAPACITY];
  logic [chm_pkg::VALUE_WIDTH-1:0] vals_mem [chm_pkg::POOL_CAPACITY];
  logic [HW-1:0] link_mem [chm_pkg::POOL_CAPACITY];
  logic [NW-1:0] fs_mem   [chm_pkg::POOL_CAPACITY];

  logic [HW-1:0] head_rdata, link_rdata;
  logic [NW-1:0] fs_rdata;
  logic [chm_pkg::KEY_WIDTH-1:0]   key_rdata;
  logic [chm_pkg::HASH_WIDTH-1:0]  hash_rdata;
  logic [chm_pkg::VALUE_WIDTH-1:0] val_rdata;
  logic [NW-1:0] node_raddr, fs_raddr;

  logic [NW-1:0] cur, prev, node, nnext, head_idx;
  logic          has_prev, found, nnext_v, head_v;
  logic [PW-1:0] steps, free_top, entries, low_mark;
  logic [chm_pkg::VALUE_WIDTH-1:0] nv;
  logic [BW-1:0] sweep_idx;

  logic slot_free, match, lv_cur, need_alloc;
  logic [NW-1:0] alloc_n;

  logic heads_we, node_we, val_we, link_we, fs_we;
  logic [BW-1:0] heads_waddr;
  logic [HW-1:0] heads_wdata, link_wdata;
  logic [NW-1:0] node_waddr, val_waddr, link_waddr;
  logic [NW-1:0] fs_waddr, fs_wdata;
  logic [chm_pkg::VALUE_WIDTH-1:0] val_wdata;
  logic [PW-1:0] free_top_next, entries_next, low_mark_next;
  logic          res_load;
  chm_pkg::res_t res_next;

  assign slot_free  = !out_valid || !out_stall;
  assign lv_cur     = link_rdata[NW];
  assign match      = (hash_rdata == req.hash) && (key_rdata == req.key);
  assign fs_raddr   = NW'(free_top - 1'b1);
  // free stack slots below the low-water mark were never pushed: slot i holds i
  assign alloc_n    = (PW'(fs_raddr) >= low_mark) ? fs_rdata : fs_raddr;
  assign node_raddr = (state == chm_pkg::ST_HEAD) ? head_rdata[NW-1:0] : link_rdata[NW-1:0];
  assign need_alloc = !found && (free_top != '0) &&
                      (req.op == chm_pkg::OP_INSERT || req.op == chm_pkg::OP_GET_OR_INSERT);

  always_ff @(posedge clk) begin
    head_rdata <= heads_mem[q_rdata.bucket];
    key_rdata  <= keys_mem[node_raddr];
    hash_rdata <= hash_mem[node_raddr];
    val_rdata  <= vals_mem[node_raddr];
    link_rdata <= link_mem[node_raddr];
    fs_rdata   <= fs_mem[fs_raddr];
    if (heads_we) begin
      heads_mem[heads_waddr] <= heads_wdata;
    end
    if (node_we) begin
      keys_mem[node_waddr] <= req.key;
      hash_mem[node_waddr] <= req.hash;
    end
    if (val_we) begin
      vals_mem[val_waddr] <= val_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      chm_pkg::ST_IDLE: begin
        if (q_not_empty && slot_free) begin
          if (q_rdata.op == chm_pkg::OP_CLEAR) begin
            state_next = chm_pkg::ST_SWEEP;
          end else if (q_rdata.op != chm_pkg::OP_NONE) begin
            state_next = chm_pkg::ST_HEAD;
          end
        end
      end
      chm_pkg::ST_HEAD: begin
        state_next = head_rdata[NW] ? chm_pkg::ST_CMP : chm_pkg::ST_DECIDE;
      end
      chm_pkg::ST_CMP: begin
        if (match || !lv_cur || steps == PW'(chm_pkg::POOL_CAPACITY - 1)) begin
          state_next = chm_pkg::ST_DECIDE;
        end
      end
      chm_pkg::ST_DECIDE: begin
        if (need_alloc) begin
          state_next = chm_pkg::ST_ALLOC;
        end else if (slot_free) begin
          state_next = chm_pkg::ST_IDLE;
        end
      end
      chm_pkg::ST_ALLOC: begin
        if (slot_free) begin
          state_next = chm_pkg::ST_IDLE;
        end
      end
      chm_pkg::ST_SWEEP: begin
        if (sweep_idx == BW'(chm_pkg::NUM_BUCKETS - 1)) begin
          state_next = chm_pkg::ST_IDLE;
        end
      end
      default: state_next = chm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    heads_we = 1'b0; heads_waddr = req.bucket; heads_wdata = {nnext_v, nnext};
    node_we = 1'b0; node_waddr = alloc_n;
    val_we = 1'b0; val_waddr = node; val_wdata = req.value;
    link_we = 1'b0; link_waddr = prev; link_wdata = {nnext_v, nnext};
    fs_we = 1'b0; fs_waddr = NW'(free_top); fs_wdata = node;
    free_top_next = free_top;
    entries_next = entries;
    low_mark_next = low_mark;
    res_load = 1'b0;
    res_next = '0;
    res_next.count = chm_pkg::COUNT_W'(entries);
    case (state)
      chm_pkg::ST_IDLE: begin
        if (q_not_empty && slot_free) begin
          q_pop = 1'b1;
          if (q_rdata.op == chm_pkg::OP_CLEAR) begin
            free_top_next = PW'(chm_pkg::POOL_CAPACITY);
            entries_next = '0;
            low_mark_next = PW'(chm_pkg::POOL_CAPACITY);
            res_load = 1'b1;
            res_next.count = '0;
          end else if (q_rdata.op == chm_pkg::OP_NONE) begin
            res_load = 1'b1;
          end
        end
      end
      chm_pkg::ST_DECIDE: begin
        if (!need_alloc && slot_free) begin
          res_load = 1'b1;
          res_next.found = found;
          case (req.op)
            chm_pkg::OP_LOOKUP: begin
              res_next.value = (found && store_values) ? nv : '0;
            end
            chm_pkg::OP_INSERT, chm_pkg::OP_GET_OR_INSERT: begin
              if (found) begin
                val_we = (req.op == chm_pkg::OP_INSERT) && store_values;
                if (req.op == chm_pkg::OP_GET_OR_INSERT && store_values) begin
                  res_next.value = nv;
                end
              end else begin
                res_next.status = 1'b1;
              end
            end
            chm_pkg::OP_REMOVE: begin
              if (found) begin
                if (has_prev) begin
                  link_we = 1'b1;
                end else begin
                  heads_we = 1'b1;
                end
                if (free_top < PW'(chm_pkg::POOL_CAPACITY)) begin
                  fs_we = 1'b1;
                  free_top_next = free_top + 1'b1;
                end
                if (entries != '0) begin
                  entries_next = entries - 1'b1;
                end
                res_next.count = chm_pkg::COUNT_W'(entries_next);
              end
            end
            default: ;
          endcase
        end
      end
      chm_pkg::ST_ALLOC: begin
        if (slot_free) begin
          node_we = 1'b1;
          val_we = 1'b1;
          val_waddr = alloc_n;
          val_wdata = store_values ? req.value : '0;
          link_we = 1'b1;
          link_waddr = alloc_n;
          link_wdata = {head_v, head_idx};
          heads_we = 1'b1;
          heads_wdata = {1'b1, alloc_n};
          free_top_next = free_top - 1'b1;
          entries_next = entries + 1'b1;
          if (PW'(fs_raddr) < low_mark) begin
            low_mark_next = PW'(fs_raddr);
          end
          res_load = 1'b1;
          res_next.is_new = 1'b1;
          if (req.op == chm_pkg::OP_GET_OR_INSERT && store_values) begin
            res_next.value = req.value;
          end
          res_next.count = chm_pkg::COUNT_W'(entries_next);
        end
      end
      chm_pkg::ST_SWEEP: begin
        heads_we = 1'b1;
        heads_waddr = sweep_idx;
        heads_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= chm_pkg::ST_SWEEP;
      free_top  <= PW'(chm_pkg::POOL_CAPACITY);
      entries   <= '0;
      low_mark  <= PW'(chm_pkg::POOL_CAPACITY);
      sweep_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      free_top <= free_top_next;
      entries  <= entries_next;
      low_mark <= low_mark_next;
      if (state == chm_pkg::ST_SWEEP) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
    if (q_pop) begin
      req <= q_rdata;
    end
    case (state)
      chm_pkg::ST_HEAD: begin
        head_idx <= head_rdata[NW-1:0];
        head_v   <= head_rdata[NW];
        cur      <= head_rdata[NW-1:0];
        has_prev <= 1'b0;
        steps    <= '0;
        found    <= 1'b0;
      end
      chm_pkg::ST_CMP: begin
        if (match) begin
          found   <= 1'b1;
          node    <= cur;
          nv      <= val_rdata;
          nnext   <= link_rdata[NW-1:0];
          nnext_v <= lv_cur;
        end else begin
          prev     <= cur;
          has_prev <= 1'b1;
          cur      <= link_rdata[NW-1:0];
          steps    <= steps + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
